### hw/rtl/owtr_pkg.sv
// Shared types, constants and helpers for the one-wire temperature reader.
// Used by every module of the block.
`timescale 1ns / 1ps
package owtr_pkg;

  localparam int LINE_COUNT = 8;
  localparam int TIMER_BITS = 10;
  localparam int CFG_COUNT  = 8;
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = $clog2(CFG_COUNT);
  localparam int CHAN_W     = 3;
  localparam int TEMP_W     = 16;

  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CMD_CONVERT    = 8'h44;
  localparam logic [7:0] CMD_READ_SCRPD = 8'hBE;

  typedef logic [TIMER_BITS-1:0]                timer_t;
  typedef logic [CFG_COUNT-1:0][TIMER_BITS-1:0] limits_t;
  typedef logic [CHAN_W-1:0]                    chan_t;
  typedef logic [3:0]                           step_t;
  typedef logic [2:0]                           bitpos_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRESENCE_WAIT = 3'd1,
    CFG_PRESENCE_TAIL = 3'd2,
    CFG_SLOT_LOW      = 3'd3,
    CFG_WRITE_HOLD    = 3'd4,
    CFG_WRITE_REC     = 3'd5,
    CFG_READ_WAIT     = 3'd6,
    CFG_READ_TAIL     = 3'd7
  } cfg_idx_t;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b00_0000_0001,
    PH_RST_LOW  = 10'b00_0000_0010,
    PH_RST_WAIT = 10'b00_0000_0100,
    PH_RST_TAIL = 10'b00_0000_1000,
    PH_W_LOW    = 10'b00_0001_0000,
    PH_W_HOLD   = 10'b00_0010_0000,
    PH_W_REC    = 10'b00_0100_0000,
    PH_R_LOW    = 10'b00_1000_0000,
    PH_R_WAIT   = 10'b01_0000_0000,
    PH_R_TAIL   = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic                     drive_low;
    chan_t                    active_channel;
    logic                     busy_res;
    logic                     done_res;
    logic                     no_presence;
    logic signed [TEMP_W-1:0] temperature;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic       load_shift;
    logic [7:0] shift;
  } entry_t;

  function automatic logic [CFG_W-1:0] cfg_default(input cfg_idx_t idx);
    logic [CFG_W-1:0] val;
    begin
      unique case (idx)
        CFG_RESET_LOW:     val = CFG_W'(500);
        CFG_PRESENCE_WAIT: val = CFG_W'(70);
        CFG_PRESENCE_TAIL: val = CFG_W'(100);
        CFG_SLOT_LOW:      val = CFG_W'(2);
        CFG_WRITE_HOLD:    val = CFG_W'(60);
        CFG_WRITE_REC:     val = CFG_W'(2);
        CFG_READ_WAIT:     val = CFG_W'(5);
        CFG_READ_TAIL:     val = CFG_W'(50);
        default:           val = '0;
      endcase
      return val;
    end
  endfunction

  // Phase and command byte that open each step of the read sequence.
  function automatic entry_t step_entry(input step_t step);
    entry_t e;
    begin
      e.phase      = PH_R_LOW;
      e.load_shift = 1'b1;
      e.shift      = 8'h00;
      unique case (step)
        4'd0, 4'd4: begin
          e.phase      = PH_RST_LOW;
          e.load_shift = 1'b0;
        end
        4'd1, 4'd5: begin
          e.phase = PH_W_LOW;
          e.shift = CMD_SKIP_ROM;
        end
        4'd2: begin
          e.phase = PH_W_LOW;
          e.shift = CMD_CONVERT;
        end
        4'd6: begin
          e.phase = PH_W_LOW;
          e.shift = CMD_READ_SCRPD;
        end
        default: begin
          e.phase = PH_R_LOW;
        end
      endcase
      return e;
    end
  endfunction

endpackage

### hw/rtl/owtr_if.sv
// Valid/ready channel interfaces for the one-wire temperature reader.
// Payload widths are written out here rather than taken from owtr_pkg.
`timescale 1ns / 1ps
interface owtr_in_if;
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [2:0]             channel;
  logic                   line_level;

  modport source (output valid, output op, output channel, output line_level, input ready);
  modport sink   (input valid, input op, input channel, input line_level, output ready);
endinterface

interface owtr_out_if;
  logic                   valid;
  logic                   ready;
  logic                   drive_low;
  logic [2:0]             active_channel;
  logic                   busy_res;
  logic                   done_res;
  logic                   no_presence;
  logic signed [15:0]     temperature;

  modport source (output valid, output drive_low, output active_channel, output busy_res,
                  output done_res, output no_presence, output temperature, input ready);
  modport sink   (input valid, input drive_low, input active_channel, input busy_res,
                  input done_res, input no_presence, input temperature, output ready);
endinterface

### hw/rtl/owtr_cfg_regs.sv
// Timing configuration registers of the one-wire reader.
// Holds the eight microsecond limits and clamps them to the timer range; uses owtr_pkg.
`timescale 1ns / 1ps
module owtr_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [owtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owtr_pkg::CFG_W-1:0] cfg_wdata,
  output owtr_pkg::limits_t          limits
);
  import owtr_pkg::*;

  localparam int CMP_W = (CFG_W > TIMER_BITS) ? CFG_W : TIMER_BITS;

  logic [CFG_COUNT-1:0][CFG_W-1:0] regs_r;
  logic [CMP_W-1:0]                tmax;

  assign tmax = CMP_W'({TIMER_BITS{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_COUNT; i++) begin
        regs_r[i] <= cfg_default(cfg_idx_t'(i));
      end
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < CFG_COUNT; i++) begin
      if (CMP_W'(regs_r[i]) > tmax) begin
        limits[i] = '1;
      end else begin
        limits[i] = TIMER_BITS'(regs_r[i]);
      end
    end
  end

endmodule

### hw/rtl/owtr_seq.sv
// Bus sequencer of the one-wire reader: phase machine, slot timer and byte shifter.
// Advances one beat per enable and forms that beat's result; uses owtr_pkg.
`timescale 1ns / 1ps
module owtr_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic              item_op,
  input  owtr_pkg::chan_t   item_channel,
  input  logic              item_level,
  input  owtr_pkg::limits_t limits,
  output owtr_pkg::result_t res
);
  import owtr_pkg::*;

  phase_t     phase_r, phase_nxt;
  timer_t     tc_r, tc_nxt, tc_inc, lim;
  bitpos_t    bit_r, bit_nxt;
  step_t      step_r, step_nxt, go_val;
  logic [7:0] shift_r, shift_nxt, low_r, low_nxt;
  chan_t      chan_r, chan_nxt;
  logic       pres_r, pres_nxt;
  logic       go, done, nopres, tmr_done;
  logic [TEMP_W-1:0] temp;
  entry_t     ent;

  always_comb begin
    phase_nxt = phase_r;
    tc_nxt    = tc_r;
    bit_nxt   = bit_r;
    step_nxt  = step_r;
    shift_nxt = shift_r;
    low_nxt   = low_r;
    chan_nxt  = chan_r;
    pres_nxt  = pres_r;
    go        = 1'b0;
    go_val    = '0;
    done      = 1'b0;
    nopres    = 1'b0;
    temp      = '0;
    tc_inc    = (tc_r == '1) ? tc_r : tc_r + 1'b1;

    unique case (phase_r)
      PH_RST_LOW:  lim = limits[CFG_RESET_LOW];
      PH_RST_WAIT: lim = limits[CFG_PRESENCE_WAIT];
      PH_RST_TAIL: lim = limits[CFG_PRESENCE_TAIL];
      PH_W_LOW:    lim = limits[CFG_SLOT_LOW];
      PH_W_HOLD:   lim = limits[CFG_WRITE_HOLD];
      PH_W_REC:    lim = limits[CFG_WRITE_REC];
      PH_R_LOW:    lim = limits[CFG_SLOT_LOW];
      PH_R_WAIT:   lim = limits[CFG_READ_WAIT];
      PH_R_TAIL:   lim = limits[CFG_READ_TAIL];
      default:     lim = '0;
    endcase
    tmr_done = (tc_inc >= lim);

    if (item_op == OP_START) begin
      if (phase_r == PH_IDLE && {1'b0, item_channel} < 4'(LINE_COUNT)) begin
        chan_nxt = item_channel;
        pres_nxt = 1'b0;
        low_nxt  = '0;
        go       = 1'b1;
        go_val   = '0;
      end
    end else if (phase_r != PH_IDLE) begin
      tc_nxt = tc_inc;
      unique case (phase_r)
        PH_RST_LOW: begin
          if (tmr_done) begin
            phase_nxt = PH_RST_WAIT;
            tc_nxt    = '0;
          end
        end
        PH_RST_WAIT: begin
          if (tmr_done) begin
            pres_nxt  = !item_level;
            phase_nxt = PH_RST_TAIL;
            tc_nxt    = '0;
          end
        end
        PH_RST_TAIL: begin
          if (tmr_done) begin
            if (!pres_r) begin
              phase_nxt = PH_IDLE;
              tc_nxt    = '0;
              done      = 1'b1;
              nopres    = 1'b1;
            end else begin
              go     = 1'b1;
              go_val = step_r + 1'b1;
            end
          end
        end
        PH_W_LOW: begin
          if (tmr_done) begin
            phase_nxt = PH_W_HOLD;
            tc_nxt    = '0;
          end
        end
        PH_W_HOLD: begin
          if (tmr_done) begin
            phase_nxt = PH_W_REC;
            tc_nxt    = '0;
          end
        end
        PH_R_LOW: begin
          if (tmr_done) begin
            phase_nxt = PH_R_WAIT;
            tc_nxt    = '0;
          end
        end
        PH_R_WAIT: begin
          if (tmr_done) begin
            if (item_level) begin
              shift_nxt[bit_r] = 1'b1;
            end
            phase_nxt = PH_R_TAIL;
            tc_nxt    = '0;
          end
        end
        PH_W_REC, PH_R_TAIL: begin
          if (tmr_done) begin
            if (bit_r == '1) begin
              if (phase_r == PH_R_TAIL && step_r >= 4'd8) begin
                temp = {shift_r, low_r};
              end
              priority if (step_r == 4'd3) begin
                go     = 1'b1;
                go_val = (shift_r != '0) ? 4'd4 : 4'd3;
              end else if (step_r == 4'd7) begin
                low_nxt = shift_r;
                go      = 1'b1;
                go_val  = 4'd8;
              end else if (step_r >= 4'd8) begin
                phase_nxt = PH_IDLE;
                tc_nxt    = '0;
                done      = 1'b1;
              end else begin
                go     = 1'b1;
                go_val = step_r + 1'b1;
              end
            end else begin
              bit_nxt   = bit_r + 1'b1;
              phase_nxt = (phase_r == PH_W_REC) ? PH_W_LOW : PH_R_LOW;
              tc_nxt    = '0;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    ent = step_entry(go_val);
    if (go) begin
      step_nxt  = go_val;
      bit_nxt   = '0;
      tc_nxt    = '0;
      phase_nxt = ent.phase;
      if (ent.load_shift) begin
        shift_nxt = ent.shift;
      end
    end

    unique case (phase_nxt)
      PH_RST_LOW, PH_W_LOW, PH_R_LOW: res.drive_low = 1'b1;
      PH_W_HOLD:                      res.drive_low = !shift_nxt[bit_nxt];
      default:                        res.drive_low = 1'b0;
    endcase
    res.active_channel = chan_nxt;
    res.busy_res       = (phase_nxt != PH_IDLE);
    res.done_res       = done;
    res.no_presence    = done && nopres;
    res.temperature    = done ? signed'(temp) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tc_r    <= '0;
      bit_r   <= '0;
      step_r  <= '0;
      shift_r <= '0;
      low_r   <= '0;
      chan_r  <= '0;
      pres_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      tc_r    <= tc_nxt;
      bit_r   <= bit_nxt;
      step_r  <= step_nxt;
      shift_r <= shift_nxt;
      low_r   <= low_nxt;
      chan_r  <= chan_nxt;
      pres_r  <= pres_nxt;
    end
  end

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.done_res |-> !res.busy_res)
    else $error("sequence reported done while still busy");

  a_nopres_no_temp: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.no_presence |-> res.temperature == '0)
    else $error("temperature reported without a presence pulse");

  a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> tc_r == '0)
    else $error("slot timer running while idle");

  a_idle_tick_stays: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && phase_r == PH_IDLE && item_op == OP_TICK |=> phase_r == PH_IDLE)
    else $error("tick left the idle phase");

endmodule

### hw/rtl/one_wire_temperature_reader.sv
// A beat is accepted into an input register, passes through owtr_seq, and its result is
// registered in the output register; one beat per cycle while the output is not stalled.
// The input stage takes a new beat while a finished result waits at the output only if its own register is empty.
// Each beat is one pass through the phase machine and slot timer in owtr_seq.
// Synchronous active-low reset clears the sequencer to idle and loads default timings.
`timescale 1ns / 1ps
module one_wire_temperature_reader (
  input  logic                           clk,
  input  logic                           rst_n,
  owtr_in_if.sink                        in_bus,
  owtr_out_if.source                     out_bus,
  input  logic                           cfg_we,
  input  logic [owtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owtr_pkg::CFG_W-1:0]     cfg_wdata
);
  import owtr_pkg::*;

  logic    in_valid_r;
  logic    in_op_r;
  chan_t   in_chan_r;
  logic    in_level_r;
  logic    out_valid_r;
  result_t out_r;
  result_t res;
  limits_t limits;
  logic    adv;

  assign adv          = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || adv;

  owtr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .limits    (limits)
  );

  owtr_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (adv),
    .item_op      (in_op_r),
    .item_channel (in_chan_r),
    .item_level   (in_level_r),
    .limits       (limits),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_op_r    <= in_bus.op;
      in_chan_r  <= in_bus.channel;
      in_level_r <= in_bus.line_level;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.drive_low      = out_r.drive_low;
  assign out_bus.active_channel = out_r.active_channel;
  assign out_bus.busy_res       = out_r.busy_res;
  assign out_bus.done_res       = out_r.done_res;
  assign out_bus.no_presence    = out_r.no_presence;
  assign out_bus.temperature    = out_r.temperature;

endmodule
